FILE: src/i2p_pkg.sv
// Types, codes and decode functions shared by the infix-to-postfix converter.
package i2p_pkg;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_expr;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol_out;
      logic       has_symbol;
      logic       last;
      logic       overflow;
      logic       unmatched;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_OPEN = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_POW  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_OPERAND = 3'd0,
      KIND_OPEN    = 3'd1,
      KIND_CLOSE   = 3'd2,
      KIND_OPER    = 3'd3,
      KIND_OTHER   = 3'd4
   } kind_type;

   typedef struct packed {
      logic   push;
      logic   pop;
      logic   clear;
      op_type code;
   } stk_cmd_type;

   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_ADD   = 8'h2B;
   localparam logic [7:0] CHAR_SUB   = 8'h2D;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_POW   = 8'h5E;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   localparam logic [1:0] PREC_POW = 2'd3;
   localparam logic [1:0] PREC_MUL = 2'd2;
   localparam logic [1:0] PREC_ADD = 2'd1;
   localparam logic [1:0] PREC_NONE = 2'd0;

   function automatic op_type op_decode(input logic [7:0] sym);
      op_type code;
      unique case (sym)
         CHAR_ADD: code = OP_ADD;
         CHAR_SUB: code = OP_SUB;
         CHAR_MUL: code = OP_MUL;
         CHAR_DIV: code = OP_DIV;
         CHAR_POW: code = OP_POW;
         default:  code = OP_OPEN;
      endcase
      return code;
   endfunction

   function automatic kind_type sym_kind(input logic [7:0] sym);
      kind_type kind;
      priority if ((sym >= CHAR_0 && sym <= CHAR_9) ||
                   (sym >= CHAR_UC_A && sym <= CHAR_UC_Z) ||
                   (sym >= CHAR_LC_A && sym <= CHAR_LC_Z)) begin
         kind = KIND_OPERAND;
      end else if (sym == CHAR_OPEN) begin
         kind = KIND_OPEN;
      end else if (sym == CHAR_CLOSE) begin
         kind = KIND_CLOSE;
      end else if (op_decode(sym) != OP_OPEN) begin
         kind = KIND_OPER;
      end else begin
         kind = KIND_OTHER;
      end
      return kind;
   endfunction

   function automatic logic [7:0] op_char(input op_type code);
      logic [7:0] ch;
      unique case (code)
         OP_OPEN: ch = CHAR_OPEN;
         OP_ADD:  ch = CHAR_ADD;
         OP_SUB:  ch = CHAR_SUB;
         OP_MUL:  ch = CHAR_MUL;
         OP_DIV:  ch = CHAR_DIV;
         OP_POW:  ch = CHAR_POW;
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] op_prec(input op_type code);
      logic [1:0] prec;
      unique case (code)
         OP_ADD, OP_SUB: prec = PREC_ADD;
         OP_MUL, OP_DIV: prec = PREC_MUL;
         OP_POW:         prec = PREC_POW;
         default:        prec = PREC_NONE;
      endcase
      return prec;
   endfunction

endpackage

FILE: src/i2p_stack.sv
// Operator stack: top-of-stack register over a memory with registered read.
module i2p_stack #(
   parameter int STACK_DEPTH = 32,
   localparam int CNT_W = $clog2(STACK_DEPTH + 1),
   localparam int IDX_W = $clog2(STACK_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  i2p_pkg::stk_cmd_type cmd,
   output logic [CNT_W-1:0]     count,
   output logic [CNT_W-1:0]     open_count,
   output i2p_pkg::op_type      top
);

   i2p_pkg::op_type mem [STACK_DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] open_ff, open_in;
   i2p_pkg::op_type  top_ff, top_in;
   i2p_pkg::op_type  rd_ff;
   logic [CNT_W-1:0] cnt_m1, cnt_m2;
   logic             full, mem_wr;

   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_m2 = count_ff - CNT_W'(2);
   assign full   = (count_ff == CNT_W'(STACK_DEPTH));
   assign mem_wr = cmd.push && !full && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      open_in  = open_ff;
      top_in   = top_ff;
      priority if (cmd.clear) begin
         count_in = '0;
         open_in  = '0;
      end else if (cmd.push) begin
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
            top_in   = cmd.code;
            if (cmd.code == i2p_pkg::OP_OPEN) begin
               open_in = open_ff + CNT_W'(1);
            end
         end
      end else if (cmd.pop) begin
         count_in = cnt_m1;
         top_in   = rd_ff;
         if (top_ff == i2p_pkg::OP_OPEN) begin
            open_in = open_ff - CNT_W'(1);
         end
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[cnt_m1[IDX_W-1:0]] <= top_ff;
      end
      rd_ff  <= mem[cnt_m2[IDX_W-1:0]];
      top_ff <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         open_ff  <= '0;
      end else begin
         count_ff <= count_in;
         open_ff  <= open_in;
      end
   end

   assign count      = count_ff;
   assign open_count = open_ff;
   assign top        = top_ff;

endmodule

FILE: src/infix_to_postfix_converter.sv
// Infix-to-postfix converter: shunting-yard sequencer over a bounded operator stack.
//
// req_* takes one ASCII character per transfer, with end_of_expr on the last
// character of an expression. rsp_* gives postfix characters one per transfer;
// the last result of an expression has last set and may carry no character.
// overflow and unmatched report the sticky flags of the expression so far.
// req_ready is high only while the sequencer is idle. An operand is emitted
// from ST_STEP into the output register; '(' and a plain operator push pass
// through ST_STEP and ST_SETTLE; every stack pop (operator or ')' unwinding,
// end flush) is followed by ST_SETTLE, which waits for the registered read of
// the stack memory. The end flush clears the stack along with its final
// result. A result sits in an output register, so the sequencer keeps
// working while the receiver holds one result and stalls only when it needs
// to load the next one.
// Reset empties the stack, clears both flags and drops any held result; no
// memory clearing pass is needed.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  i2p_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output i2p_pkg::rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_STEP   = 4'b0010,
      ST_SETTLE = 4'b0100,
      ST_FLUSH  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [7:0]            sym_ff, sym_in;
   logic                  end_ff, end_in;
   logic                  done_ff, done_in;
   logic                  ovf_ff, ovf_in;
   logic                  unm_ff, unm_in;
   logic                  rsp_valid_ff;
   i2p_pkg::rsp_type      rsp_data_ff;

   i2p_pkg::stk_cmd_type  cmd;
   logic [CNT_W-1:0]      count, open_count, ops_left;
   i2p_pkg::op_type       top, cur_code;
   i2p_pkg::kind_type     cur_kind;
   logic                  full, out_free, emit, do_pop;
   i2p_pkg::rsp_type      emit_data;
   state_type             after_char;

   i2p_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .count      (count),
      .open_count (open_count),
      .top        (top)
   );

   assign cur_kind   = i2p_pkg::sym_kind(sym_ff);
   assign cur_code   = i2p_pkg::op_decode(sym_ff);
   assign full       = (count == CNT_W'(STACK_DEPTH));
   assign ops_left   = count - open_count;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign after_char = end_ff ? ST_FLUSH : ST_IDLE;
   assign do_pop     = (count != '0) && (top != i2p_pkg::OP_OPEN) &&
                       (i2p_pkg::op_prec(top) >= i2p_pkg::op_prec(cur_code));

   always_comb begin
      state_in  = state_ff;
      sym_in    = sym_ff;
      end_in    = end_ff;
      done_in   = done_ff;
      ovf_in    = ovf_ff;
      unm_in    = unm_ff;
      cmd       = '0;
      emit      = 1'b0;
      emit_data = '0;
      emit_data.overflow  = ovf_ff;
      emit_data.unmatched = unm_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sym_in   = req_data.symbol;
               end_in   = req_data.end_of_expr;
               done_in  = 1'b0;
               state_in = ST_STEP;
               if (req_data.symbol == i2p_pkg::CHAR_CLOSE && open_count == '0) begin
                  unm_in = 1'b1;
               end
            end
         end
         ST_STEP: begin
            unique case (cur_kind)
               i2p_pkg::KIND_OPERAND: begin
                  if (out_free) begin
                     emit                 = 1'b1;
                     emit_data.symbol_out = sym_ff;
                     emit_data.has_symbol = 1'b1;
                     done_in              = 1'b1;
                     state_in             = after_char;
                  end
               end
               i2p_pkg::KIND_OPEN: begin
                  cmd.push = 1'b1;
                  cmd.code = i2p_pkg::OP_OPEN;
                  if (full) begin
                     ovf_in = 1'b1;
                  end
                  done_in  = 1'b1;
                  state_in = ST_SETTLE;
               end
               i2p_pkg::KIND_OPER: begin
                  if (do_pop) begin
                     if (out_free) begin
                        emit                 = 1'b1;
                        emit_data.symbol_out = i2p_pkg::op_char(top);
                        emit_data.has_symbol = 1'b1;
                        cmd.pop              = 1'b1;
                        state_in             = ST_SETTLE;
                     end
                  end else begin
                     cmd.push = 1'b1;
                     cmd.code = cur_code;
                     if (full) begin
                        ovf_in = 1'b1;
                     end
                     done_in  = 1'b1;
                     state_in = ST_SETTLE;
                  end
               end
               i2p_pkg::KIND_CLOSE: begin
                  if (count == '0) begin
                     done_in  = 1'b1;
                     state_in = after_char;
                  end else if (top == i2p_pkg::OP_OPEN) begin
                     cmd.pop  = 1'b1;
                     done_in  = 1'b1;
                     state_in = ST_SETTLE;
                  end else if (out_free) begin
                     emit                 = 1'b1;
                     emit_data.symbol_out = i2p_pkg::op_char(top);
                     emit_data.has_symbol = 1'b1;
                     cmd.pop              = 1'b1;
                     state_in             = ST_SETTLE;
                  end
               end
               default: begin
                  done_in  = 1'b1;
                  state_in = after_char;
               end
            endcase
         end
         ST_SETTLE: begin
            state_in = done_ff ? after_char : ST_STEP;
         end
         ST_FLUSH: begin
            if (ops_left == '0) begin
               if (out_free) begin
                  emit           = 1'b1;
                  emit_data.last = 1'b1;
                  cmd.clear      = 1'b1;
                  ovf_in         = 1'b0;
                  unm_in         = 1'b0;
                  state_in       = ST_IDLE;
               end
            end else if (top == i2p_pkg::OP_OPEN) begin
               cmd.pop  = 1'b1;
               state_in = ST_SETTLE;
            end else if (out_free) begin
               emit                 = 1'b1;
               emit_data.symbol_out = i2p_pkg::op_char(top);
               emit_data.has_symbol = 1'b1;
               if (ops_left == CNT_W'(1)) begin
                  emit_data.last = 1'b1;
                  cmd.clear      = 1'b1;
                  ovf_in         = 1'b0;
                  unm_in         = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = ST_SETTLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      end_ff  <= end_in;
      done_ff <= done_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ovf_ff       <= 1'b0;
         unm_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
         unm_ff   <= unm_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/infix_to_postfix_converter_checker.sv
// Checker for the infix-to-postfix converter: predicts postfix output and compares each transfer.
module infix_to_postfix_converter_checker #(
   parameter int STACK_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  i2p_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  i2p_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               results_due,
   output int               results_checked,
   output int               overflow_exprs,
   output int               unmatched_exprs
);

   i2p_pkg::op_type  held_ops [STACK_DEPTH];
   int               held_count = 0;
   bit               ovf_flag = 1'b0;
   bit               unm_flag = 1'b0;
   i2p_pkg::rsp_type postfix_due [$];

   int misses = 0;
   int due = 0;
   int checked = 0;
   int ovf_exprs = 0;
   int unm_exprs = 0;

   assign mismatch_count  = misses;
   assign results_due     = due;
   assign results_checked = checked;
   assign overflow_exprs  = ovf_exprs;
   assign unmatched_exprs = unm_exprs;

   function automatic i2p_pkg::op_type oper_code(logic [7:0] ch);
      case (ch)
         i2p_pkg::CHAR_ADD: return i2p_pkg::OP_ADD;
         i2p_pkg::CHAR_SUB: return i2p_pkg::OP_SUB;
         i2p_pkg::CHAR_MUL: return i2p_pkg::OP_MUL;
         i2p_pkg::CHAR_DIV: return i2p_pkg::OP_DIV;
         i2p_pkg::CHAR_POW: return i2p_pkg::OP_POW;
         default:           return i2p_pkg::OP_OPEN;
      endcase
   endfunction

   function automatic int binding(i2p_pkg::op_type code);
      case (code)
         i2p_pkg::OP_POW:                  return 3;
         i2p_pkg::OP_MUL, i2p_pkg::OP_DIV: return 2;
         i2p_pkg::OP_ADD, i2p_pkg::OP_SUB: return 1;
         default:                          return 0;
      endcase
   endfunction

   function automatic logic [7:0] oper_char(i2p_pkg::op_type code);
      case (code)
         i2p_pkg::OP_ADD: return i2p_pkg::CHAR_ADD;
         i2p_pkg::OP_SUB: return i2p_pkg::CHAR_SUB;
         i2p_pkg::OP_MUL: return i2p_pkg::CHAR_MUL;
         i2p_pkg::OP_DIV: return i2p_pkg::CHAR_DIV;
         i2p_pkg::OP_POW: return i2p_pkg::CHAR_POW;
         default:         return i2p_pkg::CHAR_OPEN;
      endcase
   endfunction

   function automatic bit is_operand(logic [7:0] ch);
      return (ch >= i2p_pkg::CHAR_0 && ch <= i2p_pkg::CHAR_9) ||
             (ch >= i2p_pkg::CHAR_UC_A && ch <= i2p_pkg::CHAR_UC_Z) ||
             (ch >= i2p_pkg::CHAR_LC_A && ch <= i2p_pkg::CHAR_LC_Z);
   endfunction

   function automatic i2p_pkg::rsp_type make_rsp(logic [7:0] ch, logic has);
      i2p_pkg::rsp_type r;
      r = '0;
      r.symbol_out = ch;
      r.has_symbol = has;
      return r;
   endfunction

   function automatic void push_op(i2p_pkg::op_type code);
      if (held_count < STACK_DEPTH) begin
         held_ops[held_count] = code;
         held_count++;
      end else begin
         ovf_flag = 1'b1;
      end
   endfunction

   function automatic void shunt_symbol(i2p_pkg::req_type item);
      i2p_pkg::rsp_type out [$];
      i2p_pkg::op_type  code;
      bit               found;
      int               flush_start;
      code = oper_code(item.symbol);
      if (is_operand(item.symbol)) begin
         out.push_back(make_rsp(item.symbol, 1'b1));
      end else if (item.symbol == i2p_pkg::CHAR_OPEN) begin
         push_op(i2p_pkg::OP_OPEN);
      end else if (code != i2p_pkg::OP_OPEN) begin
         while (held_count > 0 && held_ops[held_count - 1] != i2p_pkg::OP_OPEN &&
                binding(held_ops[held_count - 1]) >= binding(code)) begin
            out.push_back(make_rsp(oper_char(held_ops[held_count - 1]), 1'b1));
            held_count--;
         end
         push_op(code);
      end else if (item.symbol == i2p_pkg::CHAR_CLOSE) begin
         found = 1'b0;
         while (held_count > 0 && !found) begin
            held_count--;
            if (held_ops[held_count] == i2p_pkg::OP_OPEN) begin
               found = 1'b1;
            end else begin
               out.push_back(make_rsp(oper_char(held_ops[held_count]), 1'b1));
            end
         end
         if (!found) begin
            unm_flag = 1'b1;
         end
      end
      if (item.end_of_expr) begin
         flush_start = out.size();
         while (held_count > 0) begin
            held_count--;
            if (held_ops[held_count] != i2p_pkg::OP_OPEN) begin
               out.push_back(make_rsp(oper_char(held_ops[held_count]), 1'b1));
            end
         end
         if (out.size() == flush_start) begin
            out.push_back(make_rsp(i2p_pkg::CHAR_NONE, 1'b0));
         end
         out[out.size() - 1].last = 1'b1;
      end
      foreach (out[i]) begin
         out[i].overflow  = ovf_flag;
         out[i].unmatched = unm_flag;
         postfix_due.push_back(out[i]);
      end
      if (item.end_of_expr) begin
         if (ovf_flag) begin
            ovf_exprs++;
         end
         if (unm_flag) begin
            unm_exprs++;
         end
         held_count = 0;
         ovf_flag = 1'b0;
         unm_flag = 1'b0;
      end
   endfunction

   function automatic void log_miss(string what, i2p_pkg::rsp_type want);
      misses++;
      if (misses <= 10) begin
         $display("%s: expected sym %h has %b last %b ovf %b unm %b", what,
                  want.symbol_out, want.has_symbol, want.last, want.overflow, want.unmatched);
         $display("   got sym %h has %b last %b ovf %b unm %b",
                  rsp_data.symbol_out, rsp_data.has_symbol, rsp_data.last,
                  rsp_data.overflow, rsp_data.unmatched);
      end
   endfunction

   always @(posedge clock) begin
      i2p_pkg::rsp_type want;
      if (!reset) begin
         // result first: a result never comes from the symbol taken at the same edge
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (postfix_due.size() == 0) begin
               log_miss("result transfer with nothing expected", '0);
            end else begin
               want = postfix_due.pop_front();
               if (want.symbol_out !== rsp_data.symbol_out ||
                   want.has_symbol !== rsp_data.has_symbol ||
                   want.last !== rsp_data.last ||
                   want.overflow !== rsp_data.overflow ||
                   want.unmatched !== rsp_data.unmatched) begin
                  log_miss("result mismatch", want);
               end
            end
         end
         if (req_valid && req_ready) begin
            shunt_symbol(req_data);
         end
      end
      due = postfix_due.size();
   end

endmodule

FILE: verif/infix_to_postfix_converter_tb.sv
// Testbench top for the infix-to-postfix converter: expression stimulus, flow control, verdict.
module infix_to_postfix_converter_tb;

   localparam int STACK_DEPTH    = 32;
   localparam int PHASE_ITEMS    = 35;
   localparam int NOISE_PCT      = 10;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;

   typedef enum int {
      FLOW_OPEN,
      FLOW_SEND_SPARSE,
      FLOW_RECV_SLOW,
      FLOW_BOTH_LIGHT,
      FLOW_BACKPRESSURE
   } flow_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   i2p_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   i2p_pkg::rsp_type rsp_data;

   int mismatch_count;
   int results_due;
   int results_checked;
   int overflow_exprs;
   int unmatched_exprs;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit long_hold_due = 1'b0;
   int items_sent = 0;
   int exprs_sent = 0;
   int quiet_cycles = 0;
   logic [7:0] expr_chars [$];
   flow_type schedule [5] = '{FLOW_OPEN, FLOW_SEND_SPARSE, FLOW_RECV_SLOW,
                              FLOW_BOTH_LIGHT, FLOW_BACKPRESSURE};

   infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   infix_to_postfix_converter_checker #(.STACK_DEPTH(STACK_DEPTH)) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .results_due     (results_due),
      .results_checked (results_checked),
      .overflow_exprs  (overflow_exprs),
      .unmatched_exprs (unmatched_exprs)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, results_due);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_operand();
      case ($urandom_range(2))
         0:       return i2p_pkg::CHAR_0 + 8'($urandom_range(9));
         1:       return i2p_pkg::CHAR_UC_A + 8'($urandom_range(25));
         default: return i2p_pkg::CHAR_LC_A + 8'($urandom_range(25));
      endcase
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(4))
         0:       return i2p_pkg::CHAR_ADD;
         1:       return i2p_pkg::CHAR_SUB;
         2:       return i2p_pkg::CHAR_MUL;
         3:       return i2p_pkg::CHAR_DIV;
         default: return i2p_pkg::CHAR_POW;
      endcase
   endfunction

   function automatic void build_expr();
      int terms;
      int depth;
      terms = $urandom_range(1, 8);
      depth = 0;
      expr_chars.delete();
      for (int t = 0; t < terms; t++) begin
         while ($urandom_range(99) < 25) begin
            expr_chars.push_back(i2p_pkg::CHAR_OPEN);
            depth++;
         end
         expr_chars.push_back(pick_operand());
         while (depth > 0 && $urandom_range(99) < 30) begin
            expr_chars.push_back(i2p_pkg::CHAR_CLOSE);
            depth--;
         end
         if (t < terms - 1) begin
            expr_chars.push_back(pick_operator());
         end
      end
      case ($urandom_range(9))
         0: ;
         1: repeat ($urandom_range(1, 2)) expr_chars.push_back(i2p_pkg::CHAR_CLOSE);
         default: repeat (depth) expr_chars.push_back(i2p_pkg::CHAR_CLOSE);
      endcase
      // broken form now and then
      if ($urandom_range(9) == 0 && expr_chars.size() > 1) begin
         expr_chars.delete($urandom_range(expr_chars.size() - 1));
      end
   endfunction

   // nesting that may reach or pass the stack limit
   function automatic void build_deep();
      int levels;
      levels = $urandom_range(12, 20);
      expr_chars.delete();
      repeat (levels) begin
         expr_chars.push_back(i2p_pkg::CHAR_OPEN);
         expr_chars.push_back(pick_operand());
         expr_chars.push_back(pick_operator());
      end
      expr_chars.push_back(pick_operand());
      repeat ($urandom_range(levels)) expr_chars.push_back(i2p_pkg::CHAR_CLOSE);
   endfunction

   task automatic send_item(logic [7:0] sym, logic eoe);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{symbol: sym, end_of_expr: eoe};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_expr(int noise_pct);
      for (int i = 0; i < expr_chars.size(); i++) begin
         if ($urandom_range(99) < noise_pct) begin
            send_item(8'($urandom_range(255)), 1'b0);
         end
         send_item(expr_chars[i], i == expr_chars.size() - 1);
         items_sent++;
      end
      exprs_sent++;
   endtask

   task automatic send_text(string text, bit close_expr);
      for (int i = 0; i < text.len(); i++) begin
         send_item(text[i], close_expr && i == text.len() - 1);
         items_sent++;
      end
      if (close_expr) begin
         exprs_sent++;
      end
   endtask

   initial begin
      int phase_goal;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty flush, all operators, stray closes, leftover open, power chain
      send_item(i2p_pkg::CHAR_NONE, 1'b1);
      items_sent++;
      exprs_sent++;
      send_text("(A+z)*0^9-Z/a))", 1'b0);
      send_item(8'hFF, 1'b1);
      exprs_sent++;
      send_text("((a", 1'b1);
      send_text("a^b^c", 1'b1);

      // stack overflow: more opens than the stack holds
      expr_chars.delete();
      repeat (STACK_DEPTH + 2) expr_chars.push_back(i2p_pkg::CHAR_OPEN);
      expr_chars.push_back(i2p_pkg::CHAR_LC_A);
      send_expr(0);

      foreach (schedule[p]) begin
         case (schedule[p])
            FLOW_OPEN:         begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            FLOW_SEND_SPARSE:  begin send_idle_pct = 72; recv_stall_pct = 0;  end
            FLOW_RECV_SLOW:    begin send_idle_pct = 0;  recv_stall_pct = 72; end
            FLOW_BOTH_LIGHT:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            FLOW_BACKPRESSURE: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               long_hold_due = 1'b1;
            end
         endcase
         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal) begin
            if ($urandom_range(9) == 0) begin
               build_deep();
            end else begin
               build_expr();
            end
            send_expr(NOISE_PCT);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d expressions, %0d symbols plus noise, %0d postfix results checked",
               exprs_sent, items_sent, results_checked);
      $display("%0d expressions overflowed the stack, %0d had an unmatched close",
               overflow_exprs, unmatched_exprs);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
